// ===== design/cfe_pkg.sv =====
// Shared types and constants for the COBS frame encoder.
// No dependencies; the front, queue, back and top files import this package.
package cfe_pkg;

    // Encoded bytes packed into one output request.
    localparam int BYTES_PER_RESULT = 8;
    localparam int LANE_W = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

    // Group buffer: two banks of 256 bytes (254 used), ping-pong between front and back.
    localparam int IDX_W      = 8;
    localparam int BANK_DEPTH = 1 << IDX_W;
    localparam int RAM_DEPTH  = 2 * BANK_DEPTH;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);

    // Flush command queue.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] FULL_CODE  = 8'hff;
    localparam logic [7:0] FIRST_CODE = 8'h01;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] chunk;
        logic [3:0]  valid_bytes;
        logic        run_last;
        logic        frame_end;
    } t_out_item;

    // One group ready to be emitted.
    typedef struct packed {
        logic             bank;
        logic [IDX_W-1:0] len;        // buffered bytes, 0..254
        logic             trail;      // append a final code byte 0x01
        logic             frame_last;
    } t_flush_cmd;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

endpackage

// ===== design/cfe_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cfe_front.sv =====
// Front end: accepts raw bytes, runs the code counter, writes the group buffer
// and pushes a flush command per finished group. Depends on cfe_pkg.
module cfe_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  cfe_pkg::t_in_item   i_in,
    output logic                o_in_stall,
    input  logic                i_q_full,
    output cfe_pkg::t_ram_wr    o_wr,
    output logic                o_push,
    output cfe_pkg::t_flush_cmd o_cmd
);
    import cfe_pkg::*;

    logic [7:0] r_code, n_code;
    logic       r_bank, n_bank;
    logic       accept, nonzero, flush;
    logic [7:0] code_up;

    // A full queue means both banks are owned by the back end.
    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign nonzero    = (i_in.data_byte != 8'h00);
    assign code_up    = nonzero ? r_code + 8'd1 : r_code;
    assign flush      = !nonzero || (code_up == FULL_CODE) || i_in.frame_last;

    always_comb begin
        o_wr.en   = accept && nonzero;
        o_wr.addr = {r_bank, r_code - 8'd1};
        o_wr.data = i_in.data_byte;

        o_push           = accept && flush;
        o_cmd.bank       = r_bank;
        o_cmd.len        = code_up - 8'd1;
        o_cmd.trail      = !nonzero && i_in.frame_last;
        o_cmd.frame_last = i_in.frame_last;

        n_code = r_code;
        n_bank = r_bank;
        if (o_push) begin
            n_code = FIRST_CODE;
            n_bank = ~r_bank;
        end else if (accept) begin
            n_code = code_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= FIRST_CODE;
            r_bank <= 1'b0;
        end else begin
            r_code <= n_code;
            r_bank <= n_bank;
        end
    end

    // Code rests between 1 and 254; reaching 0xff always flushes.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_code != 8'h00 && r_code != FULL_CODE)
        else $error("group code out of range");

    a_push_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && nonzero && r_code == (FULL_CODE - 8'd1) |-> o_push)
        else $error("full group not flushed");

endmodule

// ===== design/cfe_queue.sv =====
// Two-entry queue of flush commands between front and back end.
// Depends on cfe_pkg.
module cfe_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cfe_pkg::t_flush_cmd i_cmd,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_nonempty,
    output cfe_pkg::t_flush_cmd o_head
);
    import cfe_pkg::*;

    t_flush_cmd        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_count;

    assign o_full     = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("flush queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("flush queue underflow");

endmodule

// ===== design/cfe_back.sv =====
// Back end: walks the head flush command one byte per cycle unless stalled (code,
// group bytes, optional 0x01) and packs them into requests. Depends on cfe_pkg.
module cfe_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_head_valid,
    input  cfe_pkg::t_flush_cmd       i_head,
    output logic                      o_pop,
    output logic [cfe_pkg::RAM_AW-1:0] o_raddr,
    input  logic [7:0]                i_rdata,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output cfe_pkg::t_out_item        o_out
);
    import cfe_pkg::*;

    logic [8:0]        r_pos, n_pos;
    logic [LANE_W-1:0] r_lane;
    logic [63:0]       r_asm;
    logic              r_ovalid;
    t_out_item         r_out;

    logic [8:0]  last_pos;
    logic        is_last, out_free, advance, complete;
    logic [7:0]  byte_val;
    logic [63:0] asm_ins;
    logic [7:0]  n_idx;

    assign last_pos = {1'b0, i_head.len} + {8'd0, i_head.trail};
    assign is_last  = (r_pos == last_pos);
    assign out_free = !r_ovalid || !i_out_stall;
    assign advance  = i_head_valid && out_free;
    assign complete = is_last || (r_lane == LANE_W'(BYTES_PER_RESULT - 1));
    assign o_pop    = advance && is_last;

    always_comb begin
        if (r_pos == 9'd0) begin
            byte_val = i_head.len + 8'd1;
        end else if (r_pos <= {1'b0, i_head.len}) begin
            byte_val = i_rdata;
        end else begin
            byte_val = FIRST_CODE;
        end
        asm_ins = r_asm;
        asm_ins[{r_lane, 3'b000} +: 8] = byte_val;

        n_pos = r_pos;
        if (advance) begin
            n_pos = is_last ? 9'd0 : r_pos + 9'd1;
        end
    end

    // Registered read: present the index the next cycle's byte will need.
    assign n_idx   = 8'(n_pos - 9'd1);
    assign o_raddr = {i_head.bank, n_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_lane   <= '0;
            r_asm    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (out_free) begin
                r_ovalid <= 1'b0;
            end
            if (advance) begin
                if (complete) begin
                    r_ovalid          <= 1'b1;
                    r_out.chunk       <= asm_ins;
                    r_out.valid_bytes <= 4'(r_lane) + 4'd1;
                    r_out.run_last    <= is_last;
                    r_out.frame_end   <= is_last && i_head.frame_last;
                    r_asm             <= '0;
                    r_lane            <= '0;
                end else begin
                    r_asm  <= asm_ins;
                    r_lane <= r_lane + LANE_W'(1);
                end
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.frame_end |-> o_out.run_last)
        else $error("frame end without run end");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.valid_bytes != 4'd0 &&
                         o_out.valid_bytes <= 4'(BYTES_PER_RESULT)))
        else $error("valid byte count out of range");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> r_pos <= last_pos)
        else $error("byte position past end of group");

endmodule

// ===== design/cobs_frame_encoder_top.sv =====
// COBS frame encoder top level. A flushing byte queues its group; the back end packs the
// first output request byte by byte. Input: one byte per cycle while a bank is free.
// Output: the byte-serial back end emits one byte per cycle unless stalled, up to 8 per
// request; a group of n bytes gives n+1 bytes, n+2 with trailer.
// Reset: synchronous active low; clears counters, queue and output valid. The group
// RAM is not cleared: every entry read is written first.
module cobs_frame_encoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // raw byte requests
    input  logic               i_in_valid,
    input  cfe_pkg::t_in_item  i_in,
    output logic               o_in_stall,
    // encoded chunk requests
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cfe_pkg::t_out_item o_out
);
    import cfe_pkg::*;

    // Front side: byte intake and group buffer writes.
    t_ram_wr    wr;
    logic       push;
    t_flush_cmd push_cmd;

    // Queue state seen by both sides.
    logic       q_full;
    logic       q_nonempty;
    t_flush_cmd head;
    logic       pop;

    // Back side read port.
    logic [RAM_AW-1:0] raddr;
    logic [7:0]        rdata;

    // Front classifies each byte: buffer it, or close the group and queue a flush.
    // It writes one RAM bank while the back end drains the other.
    cfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_wr       (wr),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Ping-pong group buffer, bank bit on top of the address.
    cfe_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_group_ram (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // A command leaves the queue only when its last byte is emitted, so the
    // queue count is also the number of banks held by the back end.
    cfe_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (push_cmd),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head)
    );

    // Back end emits code byte, buffered bytes, trailing code; output register
    // decouples it from the downstream stall.
    cfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_nonempty),
        .i_head       (head),
        .o_pop        (pop),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

endmodule

// ===== tb/cobs_frame_encoder_top_tb.sv =====
// Self-checking testbench for cobs_frame_encoder_top: random idling, a long output
// hold-off, and a bit-accurate COBS encoder model checking every chunk request.
// Depends on design/cfe_pkg.sv and design/cobs_frame_encoder_top.sv.
`timescale 1ns / 100ps

module cobs_frame_encoder_top_tb;
    import cfe_pkg::*;

    localparam int unsigned MAX_IDLE     = 16;
    localparam int unsigned HOLD_AT      = 20;      // chunk count that starts the hold-off
    localparam int unsigned HOLD_CYCLES  = 500;
    localparam int unsigned DRAIN_CYCLES = 400;     // > longest group flush (255 bytes)
    localparam int unsigned SHORT_ITEMS  = 80;
    localparam int unsigned LONG_AT      = 40;      // short bytes before the full group
    localparam logic [7:0]  ZERO_BYTE    = 8'h00;

    // One raw byte request plus the idle cycles that follow its acceptance.
    typedef struct {
        t_in_item    item;
        int unsigned gap;
    } t_raw_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_item = '0;
    logic       in_stall;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;

    t_raw_byte   raw_bytes_q[$];
    t_out_item   encoded_chunks_q[$];
    int unsigned fail_count = 0;
    bit          in_burst = 1'b0;
    bit          out_burst = 1'b0;

    // Encoder state as the block should hold it.
    logic [7:0]  grp_buf [0:253];
    logic [7:0]  grp_code = FIRST_CODE;

    cobs_frame_encoder_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in       (in_item),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Encoder model: consume one raw byte, queue the chunks it produces.
    // Nonzero bytes extend the open group; a zero byte, a full group
    // (code 0xff) or the frame's last byte flushes code + group bytes.
    // A zero byte that ends the frame adds one more code byte 0x01.
    // ------------------------------------------------------------------
    function automatic void encode_byte(input t_in_item it);
        logic [7:0]  seq[$];
        t_out_item   res;
        int unsigned cnt;
        if (it.data_byte != ZERO_BYTE) begin
            grp_buf[grp_code - 8'd1] = it.data_byte;
            grp_code = grp_code + 8'd1;
        end
        if (it.data_byte == ZERO_BYTE || grp_code == FULL_CODE || it.frame_last) begin
            seq.push_back(grp_code);
            for (int i = 0; i < int'(grp_code) - 1; i++)
                seq.push_back(grp_buf[i]);
            if (it.data_byte == ZERO_BYTE && it.frame_last)
                seq.push_back(FIRST_CODE);
            grp_code = FIRST_CODE;
        end
        // pack first byte into bits 7:0, unused upper bytes stay zero
        for (int off = 0; off < seq.size(); off += BYTES_PER_RESULT) begin
            cnt = seq.size() - off;
            if (cnt > BYTES_PER_RESULT)
                cnt = BYTES_PER_RESULT;
            res = '0;
            for (int j = 0; j < cnt; j++)
                res.chunk[8*j +: 8] = seq[off + j];
            res.valid_bytes = 4'(cnt);
            res.run_last    = (off + BYTES_PER_RESULT >= seq.size());
            res.frame_end   = res.run_last && it.frame_last;
            encoded_chunks_q.push_back(res);
        end
    endfunction

    function automatic void check_chunk(input t_out_item got);
        t_out_item want;
        if (encoded_chunks_q.size() == 0) begin
            $error("unexpected chunk %h, %0d bytes", got.chunk, got.valid_bytes);
            fail_count++;
        end else begin
            want = encoded_chunks_q.pop_front();
            if (got.chunk !== want.chunk) begin
                $error("chunk: expected %h, actual %h", want.chunk, got.chunk);
                fail_count++;
            end
            if (got.valid_bytes !== want.valid_bytes) begin
                $error("valid_bytes: expected %0d, actual %0d",
                       want.valid_bytes, got.valid_bytes);
                fail_count++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
                fail_count++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %b, actual %b", want.frame_end, got.frame_end);
                fail_count++;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_byte(input logic [7:0] data, input logic last);
        t_raw_byte req;
        req.item.data_byte  = data;
        req.item.frame_last = last;
        req.gap = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
        raw_bytes_q.push_back(req);
        // change the sender's idling style now and then
        if ($urandom_range(0, 31) == 0)
            in_burst = ($urandom_range(0, 3) == 0);
    endfunction

    // zero bytes common enough to split groups often
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0, 1:    return ZERO_BYTE;
            2:       return 8'hff;
            3:       return 8'h01;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // len bytes, the last one flagged as frame end; dense = no zero bytes
    function automatic void add_frame(input int unsigned len, input bit dense);
        for (int unsigned i = 0; i < len; i++)
            queue_byte(dense ? 8'($urandom_range(1, 255)) : pick_byte(), i == len - 1);
    endfunction

    // ------------------------------------------------------------------
    // Driver: one raw byte request per handshake, then the drawn idle gap.
    // The model is updated at the edge where the byte is accepted.
    // ------------------------------------------------------------------
    int unsigned idle_left = 0;

    always @(posedge i_clk) begin
        t_raw_byte nxt;
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            in_item   <= '0;
            idle_left <= 0;
        end else begin
            if (in_valid && !in_stall)
                encode_byte(in_item);
            if (!in_valid || !in_stall) begin
                if (idle_left != 0) begin
                    in_valid  <= 1'b0;
                    idle_left <= idle_left - 1;
                end else if (raw_bytes_q.size() != 0) begin
                    nxt = raw_bytes_q.pop_front();
                    in_valid  <= 1'b1;
                    in_item   <= nxt.item;
                    idle_left <= nxt.gap;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks every accepted chunk request and draws how long to
    // stall before the next one. Once, a long hold-off lets the block
    // fill both group banks and push back on the raw byte side.
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    int unsigned chunks_seen = 0;

    always @(posedge i_clk) begin
        int unsigned wait_next;
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            wait_next = (stall_left != 0) ? stall_left - 1 : 0;
            if (out_valid && !out_stall) begin
                check_chunk(out_item);
                chunks_seen++;
                if (chunks_seen % 24 == 0)
                    out_burst = ($urandom_range(0, 3) == 0);
                if (chunks_seen == HOLD_AT)
                    wait_next = HOLD_CYCLES;
                else
                    wait_next = out_burst ? 0 : $urandom_range(0, MAX_IDLE);
            end
            stall_left <= wait_next;
            out_stall  <= (wait_next != 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int unsigned short_cnt;
        int unsigned len;
        // directed: single-byte frames, zero ending a frame, runs of zeros
        queue_byte(ZERO_BYTE, 1'b1);         // frame of one zero: 01 01
        queue_byte(8'hff, 1'b1);
        queue_byte(8'h01, 1'b1);
        queue_byte(ZERO_BYTE, 1'b0);
        queue_byte(ZERO_BYTE, 1'b0);
        queue_byte(ZERO_BYTE, 1'b1);
        queue_byte(8'h11, 1'b0);              // zero in mid frame
        queue_byte(8'h22, 1'b0);
        queue_byte(ZERO_BYTE, 1'b0);
        queue_byte(8'h33, 1'b1);
        // eight nonzero bytes: nine output bytes, spills into a second chunk
        for (int i = 0; i < 8; i++)
            queue_byte(8'h80 >> i, i == 7);
        // seven nonzero bytes fill exactly one chunk
        for (int i = 0; i < 7; i++)
            queue_byte((i % 2 == 0) ? 8'haa : 8'h55, i == 6);

        // random frames, mostly short; one long one hits the full-group case
        short_cnt = 0;
        while (short_cnt < SHORT_ITEMS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
            add_frame(len, 1'b0);
            short_cnt += len;
            if (short_cnt >= LONG_AT && short_cnt - len < LONG_AT)
                add_frame(254, 1'b1);         // full group ends the frame: no trailer
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sampled on the falling edge so driver updates have settled
        while (raw_bytes_q.size() != 0 || in_valid)
            @(negedge i_clk);
        while (encoded_chunks_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && encoded_chunks_q.size() == 0)
            $display("cobs_frame_encoder_top verification clean");
        else
            $display("cobs_frame_encoder_top verification failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("cobs_frame_encoder_top verification failed");
        $finish;
    end

endmodule

// ===== cobs_frame_encoder_top.f =====
design/cfe_pkg.sv
design/cfe_ram.sv
design/cfe_front.sv
design/cfe_queue.sv
design/cfe_back.sv
design/cobs_frame_encoder_top.sv
tb/cobs_frame_encoder_top_tb.sv
